[rtl/idsd_pkg.sv]
// Shared types, codes and tables of the laser file decoder.
`default_nettype none
package idsd_pkg;

   localparam int PALETTE_SETS  = 8;
   localparam int PALETTE_DEPTH = 256;
   localparam int PROJ_W = (PALETTE_SETS > 1) ? $clog2(PALETTE_SETS) : 1;
   localparam int PAL_ADDR_W = PROJ_W + $clog2(PALETTE_DEPTH);
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);

   localparam logic [23:0] MAX_POINTS_RESET = 24'd1000000;
   localparam logic [15:0] MAX_FRAMES_RESET = 16'd65535;

   localparam logic CSR_MAX_POINTS = 1'b0;
   localparam logic CSR_MAX_FRAMES = 1'b1;

   localparam logic [3:0] ST_POINT     = 4'd0;
   localparam logic [3:0] ST_END_OK    = 4'd1;
   localparam logic [3:0] ST_BAD_SIG   = 4'd2;
   localparam logic [3:0] ST_BAD_FMT   = 4'd3;
   localparam logic [3:0] ST_BAD_PAL   = 4'd4;
   localparam logic [3:0] ST_TRUNC     = 4'd5;
   localparam logic [3:0] ST_LIMIT     = 4'd6;
   localparam logic [3:0] ST_NO_END    = 4'd7;
   localparam logic [3:0] ST_BAD_PROJ  = 4'd8;

   localparam logic [7:0] FMT_3D_IDX   = 8'd0;
   localparam logic [7:0] FMT_2D_IDX   = 8'd1;
   localparam logic [7:0] FMT_PALETTE  = 8'd2;
   localparam logic [7:0] FMT_3D_TRUE  = 8'd4;
   localparam logic [7:0] FMT_2D_TRUE  = 8'd5;

   localparam logic [7:0] SIG_BYTES [4] = '{8'h49, 8'h4C, 8'h44, 8'h41};
   localparam logic [7:0] GB_RAMP [8] = '{8'd0, 8'd36, 8'd73, 8'd109,
                                          8'd146, 8'd182, 8'd219, 8'd255};
   localparam logic [7:0] CG_RAMP [9] = '{8'd227, 8'd198, 8'd170, 8'd142,
                                          8'd113, 8'd85, 8'd56, 8'd28, 8'd0};
   localparam logic [7:0] BLANK_MASK = 8'h40;

   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PALETTE = 3'b010,
      PH_POINTS  = 3'b100
   } phase_type;

   typedef struct packed {
      logic [3:0]         status;
      logic signed [15:0] x_pos;
      logic signed [15:0] y_pos;
      logic signed [15:0] z_pos;
      logic [7:0]         red;
      logic [7:0]         green;
      logic [7:0]         blue;
      logic               blanked;
      logic               three_d;
      logic [7:0]         projector_id;
      logic [15:0]        frame_number;
      logic               last_in_frame;
   } rsp_type;

   typedef struct packed {
      logic    pt_valid;
      logic    st_valid;
      logic    use_ram;
      logic [3:0] status;
      rsp_type pt;
   } stage_type;

   typedef struct packed {
      logic                  en;
      logic [PAL_ADDR_W-1:0] addr;
      logic [23:0]           data;
   } pal_wr_type;

   typedef struct packed {
      logic        wr;
      logic        index;
      logic [23:0] data;
   } csr_type;

   function automatic logic [23:0] default_colour(input logic [7:0] i);
      logic [7:0] r, g, b, t;
      r = 8'd0; g = 8'd0; b = 8'd0; t = 8'd0;
      if (i < 8'd16) begin
         r = 8'd255; g = {i[3:0], 4'b0};
      end else if (i == 8'd16) begin
         r = 8'd255; g = 8'd255;
      end else if (i < 8'd24) begin
         t = 8'd24 - i; r = {t[2:0], 5'b0}; g = 8'd255;
      end else if (i < 8'd32) begin
         g = 8'd255; b = GB_RAMP[i[2:0]];
      end else if (i < 8'd41) begin
         t = i - 8'd32; g = CG_RAMP[t[3:0]]; b = 8'd255;
      end else if (i < 8'd48) begin
         t = i - 8'd40; r = {t[2:0], 5'b0}; b = 8'd255;
      end else if (i == 8'd48) begin
         r = 8'd255; b = 8'd255;
      end else if (i < 8'd56) begin
         t = i - 8'd48; r = 8'd255; g = {t[2:0], 5'b0}; b = 8'd255;
      end else if (i == 8'd56) begin
         r = 8'd255; g = 8'd255; b = 8'd255;
      end else if (i < 8'd64) begin
         t = 8'd64 - i; r = 8'd255; g = {t[2:0], 5'b0}; b = {t[2:0], 5'b0};
      end
      return {r, g, b};
   endfunction

endpackage
`default_nettype wire

[rtl/idsd_palette_ram.sv]
// Single-port-write, registered-read colour memory.
`default_nettype none
module idsd_palette_ram #(
   parameter int ADDR_W = 11,
   parameter int DATA_W = 24
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);
   logic [DATA_W-1:0] mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

[rtl/idsd_parser.sv]
// Byte parser: header checks, palette loading, point assembly, limits.
`default_nettype none
module idsd_parser (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  accept,
   input  wire logic [7:0]            data_byte,
   input  wire logic                  end_of_file,
   input  wire idsd_pkg::csr_type     csr,
   output idsd_pkg::pal_wr_type       pal_wr,
   output logic [idsd_pkg::PAL_ADDR_W-1:0] pal_rd_addr,
   output idsd_pkg::stage_type        stage
);
   import idsd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [4:0]  pos_ff, pos_in;
   logic [15:0] idx_ff, idx_in;
   logic        sig_bad_ff, sig_bad_in;
   logic [7:0]  fmt_ff, fmt_in;
   logic [15:0] cnt_ff, cnt_in;
   logic [7:0]  proj_ff, proj_in;
   logic [7:0]  rb_ff [10];
   logic [7:0]  rb_cur [10];
   logic [8:0]  loaded_ff [PALETTE_SETS];
   logic        load_en;
   logic [23:0] points_ff, points_in;
   logic [15:0] frames_ff, frames_in;
   logic        finished_ff, finished_in;
   logic [23:0] max_points_ff;
   logic [15:0] max_frames_ff;
   stage_type   stage_ff, stage_in;

   logic [3:0]  stride;
   logic [3:0]  st_i;
   logic        three;
   logic        fmt_ok;
   logic [24:0] pts_sum;
   logic [16:0] idx_next;
   logic [PROJ_W-1:0] proj_sel;
   logic [8:0]  n_loaded;
   logic [7:0]  col_idx;
   logic [4:0]  p;

   assign proj_sel = proj_ff[PROJ_W-1:0];
   assign n_loaded = loaded_ff[proj_sel];
   assign idx_next = {1'b0, idx_ff} + 17'd1;
   assign p = pos_ff;

   always_comb begin
      for (int i = 0; i < 10; i++) begin
         rb_cur[i] = (p[3:0] == 4'(i)) ? data_byte : rb_ff[i];
      end
   end

   always_comb begin
      case (fmt_ff)
         FMT_2D_IDX:  stride = 4'd6;
         FMT_3D_TRUE: stride = 4'd10;
         default:     stride = 4'd8;
      endcase
      three = (fmt_ff == FMT_3D_IDX) || (fmt_ff == FMT_3D_TRUE);
      st_i  = three ? 4'd6 : 4'd4;
      col_idx = rb_cur[st_i + 4'd1];
   end

   assign pal_rd_addr = {proj_sel, col_idx};

   always_comb begin
      phase_in    = phase_ff;
      pos_in      = pos_ff;
      idx_in      = idx_ff;
      sig_bad_in  = sig_bad_ff;
      fmt_in      = fmt_ff;
      cnt_in      = cnt_ff;
      proj_in     = proj_ff;
      points_in   = points_ff;
      frames_in   = frames_ff;
      finished_in = finished_ff;
      load_en     = 1'b0;
      pal_wr.en   = 1'b0;
      pal_wr.addr = {proj_sel, idx_ff[7:0]};
      pal_wr.data = {rb_ff[0], rb_ff[1], data_byte};
      stage_in    = '0;
      fmt_ok      = 1'b0;
      pts_sum     = {1'b0, points_ff} + {9'd0, cnt_ff};

      if (accept && !finished_ff) begin
         case (phase_ff)
            PH_HEADER: begin
               if (p == 5'd0) begin
                  sig_bad_in = 1'b0; fmt_in = '0; cnt_in = '0; proj_in = '0;
               end
               if (p < 5'd4 && data_byte != SIG_BYTES[p[1:0]]) sig_bad_in = 1'b1;
               else if (p == 5'd7)  fmt_in = data_byte;
               else if (p == 5'd24) cnt_in[15:8] = data_byte;
               else if (p == 5'd25) cnt_in[7:0] = data_byte;
               else if (p == 5'd30) proj_in = data_byte;
               pos_in = p + 5'd1;
               if (p == 5'd31) begin
                  pos_in  = '0;
                  idx_in  = '0;
                  pts_sum = {1'b0, points_ff} + {9'd0, cnt_in};
                  fmt_ok  = (fmt_in == FMT_3D_IDX) || (fmt_in == FMT_2D_IDX) ||
                            (fmt_in == FMT_PALETTE) || (fmt_in == FMT_3D_TRUE) ||
                            (fmt_in == FMT_2D_TRUE);
                  stage_in.st_valid = 1'b1;
                  if (sig_bad_in) stage_in.status = ST_BAD_SIG;
                  else if (!fmt_ok) stage_in.status = ST_BAD_FMT;
                  else if (cnt_in == 16'd0 && fmt_in != FMT_PALETTE)
                     stage_in.status = ST_END_OK;
                  else if (fmt_in == FMT_PALETTE && (cnt_in < 16'd2 || cnt_in > 16'd256))
                     stage_in.status = ST_BAD_PAL;
                  else if ({1'b0, proj_in} >= 9'(PALETTE_SETS))
                     stage_in.status = ST_BAD_PROJ;
                  else if (fmt_in == FMT_PALETTE) begin
                     stage_in.st_valid = 1'b0;
                     load_en  = 1'b1;
                     phase_in = PH_PALETTE;
                  end else if (pts_sum > {1'b0, max_points_ff} || frames_ff >= max_frames_ff)
                     stage_in.status = ST_LIMIT;
                  else begin
                     stage_in.st_valid = 1'b0;
                     points_in = pts_sum[23:0];
                     phase_in  = PH_POINTS;
                  end
                  if (stage_in.st_valid) finished_in = 1'b1;
               end
            end
            PH_PALETTE: begin
               if (p[1:0] == 2'd2) begin
                  pal_wr.en = 1'b1;
                  pos_in = '0;
                  idx_in = idx_next[15:0];
                  if (idx_next >= {1'b0, cnt_ff}) begin
                     idx_in = '0;
                     phase_in = PH_HEADER;
                  end
               end else begin
                  pos_in = p + 5'd1;
               end
            end
            PH_POINTS: begin
               pos_in = p + 5'd1;
               if (p[3:0] == stride - 4'd1) begin
                  stage_in.pt_valid = 1'b1;
                  stage_in.pt.status = ST_POINT;
                  stage_in.pt.x_pos = {rb_cur[0], rb_cur[1]};
                  stage_in.pt.y_pos = {rb_cur[2], rb_cur[3]};
                  stage_in.pt.z_pos = three ? {rb_cur[4], rb_cur[5]} : 16'sd0;
                  stage_in.pt.blanked = (rb_cur[st_i] & BLANK_MASK) != 8'd0;
                  stage_in.pt.three_d = three;
                  stage_in.pt.projector_id = proj_ff;
                  stage_in.pt.frame_number = frames_ff;
                  stage_in.pt.last_in_frame = idx_next >= {1'b0, cnt_ff};
                  if (fmt_ff == FMT_3D_IDX || fmt_ff == FMT_2D_IDX) begin
                     if (n_loaded == 9'd0)
                        {stage_in.pt.red, stage_in.pt.green, stage_in.pt.blue} =
                           default_colour(col_idx);
                     else if ({1'b0, col_idx} < n_loaded)
                        stage_in.use_ram = 1'b1;
                  end else begin
                     stage_in.pt.red   = rb_cur[st_i + 4'd3];
                     stage_in.pt.green = rb_cur[st_i + 4'd2];
                     stage_in.pt.blue  = rb_cur[st_i + 4'd1];
                  end
                  pos_in = '0;
                  idx_in = idx_next[15:0];
                  if (stage_in.pt.last_in_frame) begin
                     idx_in    = '0;
                     frames_in = frames_ff + 16'd1;
                     phase_in  = PH_HEADER;
                  end
               end
            end
            default: phase_in = PH_HEADER;
         endcase
         if (end_of_file && !finished_in) begin
            stage_in.st_valid = 1'b1;
            stage_in.status = (phase_in == PH_HEADER) ? ST_NO_END : ST_TRUNC;
            finished_in = 1'b1;
         end
      end
   end

   assign stage = stage_ff;

   always_ff @(posedge clock) begin
      if (accept && !finished_ff) begin
         if (phase_ff == PH_PALETTE && p[1:0] != 2'd2) rb_ff[p[1:0]] <= data_byte;
         if (phase_ff == PH_POINTS) begin
            for (int i = 0; i < 10; i++) rb_ff[i] <= rb_cur[i];
         end
      end
      if (reset) begin
         phase_ff      <= PH_HEADER;
         pos_ff        <= '0;
         idx_ff        <= '0;
         points_ff     <= '0;
         frames_ff     <= '0;
         finished_ff   <= 1'b0;
         stage_ff      <= '0;
         max_points_ff <= MAX_POINTS_RESET;
         max_frames_ff <= MAX_FRAMES_RESET;
         sig_bad_ff    <= 1'b0;
         fmt_ff        <= '0;
         cnt_ff        <= '0;
         proj_ff       <= '0;
         for (int i = 0; i < PALETTE_SETS; i++) loaded_ff[i] <= '0;
      end else begin
         phase_ff    <= phase_in;
         pos_ff      <= pos_in;
         idx_ff      <= idx_in;
         points_ff   <= points_in;
         frames_ff   <= frames_in;
         finished_ff <= finished_in;
         stage_ff    <= stage_in;
         sig_bad_ff  <= sig_bad_in;
         fmt_ff      <= fmt_in;
         cnt_ff      <= cnt_in;
         proj_ff     <= proj_in;
         if (load_en) loaded_ff[proj_in[PROJ_W-1:0]] <= cnt_in[8:0];
         if (csr.wr) begin
            case (csr.index)
               CSR_MAX_POINTS: max_points_ff <= csr.data;
               CSR_MAX_FRAMES: max_frames_ff <= csr.data[15:0];
               default: ;
            endcase
         end
      end
   end
endmodule
`default_nettype wire

[rtl/idsd_out_queue.sv]
// Colour merge and result queue in front of the output channel.
`default_nettype none
module idsd_out_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire idsd_pkg::stage_type stage,
   input  wire logic [23:0]         ram_colour,
   input  wire logic                pop,
   output logic                     not_empty,
   output logic                     busy,
   output idsd_pkg::rsp_type        head
);
   import idsd_pkg::*;

   rsp_type q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] rd_ff, wr_ff;
   logic [QPTR_W:0]   count_ff;
   rsp_type pt_word, st_word;
   logic [QPTR_W-1:0] st_slot;
   logic [1:0] pushes;

   always_comb begin
      pt_word = stage.pt;
      if (stage.use_ram) {pt_word.red, pt_word.green, pt_word.blue} = ram_colour;
      st_word = '0;
      st_word.status = stage.status;
      st_slot = wr_ff + QPTR_W'(stage.pt_valid);
      pushes = {1'b0, stage.pt_valid} + {1'b0, stage.st_valid};
   end

   assign not_empty = count_ff != '0;
   assign head = q_ff[rd_ff];
   // room for the worst case of two words behind the one in flight
   assign busy = ({1'b0, count_ff} + (QPTR_W+2)'(stage.pt_valid) +
                  (QPTR_W+2)'(stage.st_valid)) > (QPTR_W+2)'(QUEUE_DEPTH - 2);

   always_ff @(posedge clock) begin
      if (stage.pt_valid) q_ff[wr_ff] <= pt_word;
      if (stage.st_valid) q_ff[st_slot] <= st_word;
      if (reset) begin
         rd_ff <= '0; wr_ff <= '0; count_ff <= '0;
      end else begin
         wr_ff <= wr_ff + QPTR_W'(pushes);
         rd_ff <= rd_ff + QPTR_W'(pop);
         count_ff <= count_ff + (QPTR_W+1)'(pushes) - (QPTR_W+1)'(pop);
      end
   end
endmodule
`default_nettype wire

[rtl/ilda_stream_decoder_unit.sv]
// Top level of the laser file stream decoder.
// Usage:
//  req_*: one file byte per word, req_end_of_file marks the last byte.
//  rsp_*: one word per decoded point, then a single status word
//         (end ok or an error); on an error the points already sent are void.
//  csr_*: writes max_points (index 0) and max_frames (index 1); always ready.
// A byte is taken each cycle while req_stall is low. A point word and its palette
// memory read are registered in the parser stage, then the word goes through the
// four-word result queue. req_stall rises when the queue cannot take two more
// words, so a stalled receiver holds off the byte stream after a few words.
// After a status word, further bytes are taken and dropped until reset.
// Reset is synchronous; it clears parser state, limits to their defaults and
// every projector's palette back to the built-in table. Palette memory content
// is not cleared; entries are only read once loaded.
`default_nettype none
module ilda_stream_decoder_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [7:0]         req_data_byte,
   input  wire logic               req_end_of_file,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [3:0]              rsp_status,
   output logic signed [15:0]      rsp_x_pos,
   output logic signed [15:0]      rsp_y_pos,
   output logic signed [15:0]      rsp_z_pos,
   output logic [7:0]              rsp_red,
   output logic [7:0]              rsp_green,
   output logic [7:0]              rsp_blue,
   output logic                    rsp_blanked,
   output logic                    rsp_three_d,
   output logic [7:0]              rsp_projector_id,
   output logic [15:0]             rsp_frame_number,
   output logic                    rsp_last_in_frame,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic               csr_index,
   input  wire logic [23:0]        csr_data
);
   import idsd_pkg::*;

   csr_type    csr;
   pal_wr_type pal_wr;
   logic [PAL_ADDR_W-1:0] pal_rd_addr;
   logic [23:0] ram_colour;
   stage_type  stage;
   rsp_type    head;
   logic       busy;

   assign csr_ready = 1'b1;
   assign csr.wr    = csr_valid & csr_ready;
   assign csr.index = csr_index;
   assign csr.data  = csr_data;
   assign req_stall = busy;

   idsd_parser u_parser (
      .clock(clock), .reset(reset),
      .accept(req_valid & ~req_stall),
      .data_byte(req_data_byte), .end_of_file(req_end_of_file),
      .csr(csr), .pal_wr(pal_wr), .pal_rd_addr(pal_rd_addr), .stage(stage)
   );

   idsd_palette_ram #(.ADDR_W(PAL_ADDR_W), .DATA_W(24)) u_ram (
      .clock(clock), .wr_en(pal_wr.en), .wr_addr(pal_wr.addr),
      .wr_data(pal_wr.data), .rd_addr(pal_rd_addr), .rd_data(ram_colour)
   );

   idsd_out_queue u_queue (
      .clock(clock), .reset(reset), .stage(stage), .ram_colour(ram_colour),
      .pop(rsp_valid & ~rsp_stall), .not_empty(rsp_valid), .busy(busy),
      .head(head)
   );

   assign rsp_status        = head.status;
   assign rsp_x_pos         = head.x_pos;
   assign rsp_y_pos         = head.y_pos;
   assign rsp_z_pos         = head.z_pos;
   assign rsp_red           = head.red;
   assign rsp_green         = head.green;
   assign rsp_blue          = head.blue;
   assign rsp_blanked       = head.blanked;
   assign rsp_three_d       = head.three_d;
   assign rsp_projector_id  = head.projector_id;
   assign rsp_frame_number  = head.frame_number;
   assign rsp_last_in_frame = head.last_in_frame;
endmodule
`default_nettype wire

[rtl/idsd_checker.sv]
// Port-level checks of the decoder and their binding.
`default_nettype none
module idsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [3:0]  rsp_status,
   input wire logic [15:0] rsp_x_pos,
   input wire logic [15:0] rsp_z_pos,
   input wire logic [7:0]  rsp_red,
   input wire logic [15:0] rsp_frame_number,
   input wire logic        rsp_three_d
);
   import idsd_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("result word changed while stalled");

   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_status != ST_POINT |=> !rsp_valid)
      else $error("word after a status word");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_POINT |->
         rsp_x_pos == 16'd0 && rsp_red == 8'd0 && rsp_frame_number == 16'd0)
      else $error("status word carries point data");

   a_flat_z: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_POINT && !rsp_three_d |-> rsp_z_pos == 16'd0)
      else $error("2D point with nonzero z");
endmodule

bind ilda_stream_decoder_unit idsd_checker u_checker (
   .clock(clock), .reset(reset), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_status(rsp_status), .rsp_x_pos(rsp_x_pos), .rsp_z_pos(rsp_z_pos),
   .rsp_red(rsp_red), .rsp_frame_number(rsp_frame_number),
   .rsp_three_d(rsp_three_d)
);
`default_nettype wire

[verif/ilda_stream_decoder_unit_tb.sv]
// Self-checking testbench of the laser file stream decoder.
`default_nettype none
module ilda_stream_decoder_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import idsd_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   typedef struct {
      logic [7:0] data;
      logic       eof;
   } file_byte_type;

   logic clock, reset;
   logic req_valid, req_stall, req_end_of_file;
   logic [7:0] req_data_byte;
   logic rsp_valid, rsp_stall;
   logic [3:0] rsp_status;
   logic signed [15:0] rsp_x_pos, rsp_y_pos, rsp_z_pos;
   logic [7:0] rsp_red, rsp_green, rsp_blue, rsp_projector_id;
   logic rsp_blanked, rsp_three_d, rsp_last_in_frame;
   logic [15:0] rsp_frame_number;
   logic csr_valid, csr_ready, csr_index;
   logic [23:0] csr_data;

   ilda_stream_decoder_unit u_top (.*);

   // stimulus and expectations
   file_byte_type file_bytes[$];
   rsp_type       expected_words[$];
   int unsigned   mismatches = 0, words_seen = 0, cycles = 0;
   bit            calm = 0;
   int unsigned   req_gap = 0, rsp_gap = 0, long_hold = 0;
   bit            long_done = 0;

   // decoder model state
   int unsigned   lim_points = MAX_POINTS_RESET, lim_frames = MAX_FRAMES_RESET;
   phase_type     phase = PH_HEADER;
   bit            sig_bad, done = 0;
   logic [7:0]    hdr_fmt, hdr_cnt_hi, hdr_cnt_lo, hdr_proj;
   int unsigned   pos = 0, pts_total = 0, frm_total = 0;
   logic [7:0]    rec [10];
   logic [23:0]   pal_mem [PALETTE_SETS][PALETTE_DEPTH];
   int unsigned   pal_count [PALETTE_SETS];

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      reset = 1; req_valid = 0; req_data_byte = 0; req_end_of_file = 0;
      rsp_stall = 0; csr_valid = 0; csr_index = CSR_MAX_POINTS; csr_data = 0;
      for (int i = 0; i < PALETTE_SETS; i++) pal_count[i] = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   function automatic logic [23:0] builtin_colour(int unsigned i);
      logic [7:0] r, g, b;
      r = 0; g = 0; b = 0;
      if (i < 16) begin r = 255; g = 8'(i * 16); end
      else if (i == 16) begin r = 255; g = 255; end
      else if (i < 24) begin r = 8'((24 - i) * 32); g = 255; end
      else if (i < 32) begin g = 255; b = GB_RAMP[i - 24]; end
      else if (i < 41) begin g = CG_RAMP[i - 32]; b = 255; end
      else if (i < 48) begin r = 8'((i - 40) * 32); b = 255; end
      else if (i == 48) begin r = 255; b = 255; end
      else if (i < 56) begin r = 255; g = 8'((i - 48) * 32); b = 255; end
      else if (i == 56) begin r = 255; g = 255; b = 255; end
      else if (i < 64) begin r = 255; g = 8'((64 - i) * 32); b = g; end
      return {r, g, b};
   endfunction

   function automatic logic [23:0] lookup_colour(int unsigned proj, int unsigned idx);
      if (pal_count[proj] == 0) return builtin_colour(idx);
      if (idx < pal_count[proj]) return pal_mem[proj][idx];
      return 24'h0;
   endfunction

   task automatic post_status(logic [3:0] st);
      rsp_type w;
      w = '0;
      w.status = st;
      expected_words.push_back(w);
      done = 1;
   endtask

   task automatic close_header();
      int unsigned cnt;
      cnt = {hdr_cnt_hi, hdr_cnt_lo};
      if (sig_bad) post_status(ST_BAD_SIG);
      else if (!(hdr_fmt inside {FMT_3D_IDX, FMT_2D_IDX, FMT_PALETTE, FMT_3D_TRUE,
                                 FMT_2D_TRUE})) post_status(ST_BAD_FMT);
      else if (cnt == 0 && hdr_fmt != FMT_PALETTE) post_status(ST_END_OK);
      else if (hdr_fmt == FMT_PALETTE && (cnt < 2 || cnt > 256)) post_status(ST_BAD_PAL);
      else if (hdr_proj >= PALETTE_SETS) post_status(ST_BAD_PROJ);
      else if (hdr_fmt == FMT_PALETTE) begin
         pal_count[hdr_proj] = cnt;
         phase = PH_PALETTE;
      end else if (pts_total + cnt > lim_points || frm_total >= lim_frames)
         post_status(ST_LIMIT);
      else begin
         pts_total += cnt;
         phase = PH_POINTS;
      end
   endtask

   task automatic decode_byte(logic [7:0] b, logic eof);
      int unsigned p, cnt, stride, idx, st;
      bit three;
      logic [23:0] col;
      rsp_type w;
      if (done) return;
      cnt = {hdr_cnt_hi, hdr_cnt_lo};
      case (phase)
         PH_HEADER: begin
            p = pos % 32;
            if (p == 0) begin
               sig_bad = 0; hdr_fmt = 0; hdr_cnt_hi = 0; hdr_cnt_lo = 0; hdr_proj = 0;
            end
            if (p < 4 && b != SIG_BYTES[p]) sig_bad = 1;
            else if (p == 7) hdr_fmt = b;
            else if (p == 24) hdr_cnt_hi = b;
            else if (p == 25) hdr_cnt_lo = b;
            else if (p == 30) hdr_proj = b;
            pos = (p == 31) ? 0 : p + 1;
            if (p == 31) close_header();
         end
         PH_PALETTE: begin
            rec[pos % 3] = b;
            if (pos % 3 == 2) pal_mem[hdr_proj][pos / 3] = {rec[0], rec[1], rec[2]};
            pos++;
            if (pos >= cnt * 3) begin
               pos = 0;
               phase = PH_HEADER;
            end
         end
         default: begin
            stride = (hdr_fmt == FMT_3D_IDX) ? 8 : (hdr_fmt == FMT_2D_IDX) ? 6 :
                     (hdr_fmt == FMT_3D_TRUE) ? 10 : 8;
            idx = pos / stride;
            p = pos % stride;
            rec[p] = b;
            pos++;
            if (p == stride - 1) begin
               three = (hdr_fmt == FMT_3D_IDX || hdr_fmt == FMT_3D_TRUE);
               st = three ? 6 : 4;
               if (hdr_fmt == FMT_3D_IDX || hdr_fmt == FMT_2D_IDX)
                  col = lookup_colour(hdr_proj, rec[st + 1]);
               else col = {rec[st + 3], rec[st + 2], rec[st + 1]};
               w = '0;
               w.status = ST_POINT;
               w.x_pos = {rec[0], rec[1]};
               w.y_pos = {rec[2], rec[3]};
               w.z_pos = three ? {rec[4], rec[5]} : 16'h0;
               {w.red, w.green, w.blue} = col;
               w.blanked = (rec[st] & BLANK_MASK) != 0;
               w.three_d = three;
               w.projector_id = hdr_proj;
               w.frame_number = frm_total[15:0];
               w.last_in_frame = (idx + 1 >= cnt);
               expected_words.push_back(w);
               if (w.last_in_frame) begin
                  frm_total = (frm_total + 1) & 16'hFFFF;
                  pos = 0;
                  phase = PH_HEADER;
               end
            end
         end
      endcase
      if (eof && !done) post_status(phase == PH_HEADER ? ST_NO_END : ST_TRUNC);
   endtask

   // byte driver: model is advanced on every accepted word
   always @(posedge clock) begin
      file_byte_type fb;
      if (reset) begin
         req_valid <= 0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) decode_byte(req_data_byte, req_end_of_file);
         if (req_gap > 0) begin
            req_gap <= req_gap - 1;
            req_valid <= 0;
         end else if (file_bytes.size() != 0) begin
            fb = file_bytes.pop_front();
            req_valid <= 1;
            req_data_byte <= fb.data;
            req_end_of_file <= fb.eof;
            if (!calm && $urandom_range(0, 15) == 0) req_gap <= $urandom_range(1, 9);
         end else begin
            req_valid <= 0;
         end
      end
   end

   // result stall: random bursts plus one long hold once points are flowing
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (long_hold > 0) begin
         long_hold <= long_hold - 1;
         rsp_stall <= 1;
      end else if (!long_done && words_seen >= 30) begin
         long_done <= 1;
         long_hold <= 300;
         rsp_stall <= 1;
      end else if (rsp_gap > 0) begin
         rsp_gap <= rsp_gap - 1;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 11) == 0) begin
         rsp_gap <= $urandom_range(0, 8);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      rsp_type got, want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = {rsp_status, rsp_x_pos, rsp_y_pos, rsp_z_pos, rsp_red, rsp_green, rsp_blue,
                rsp_blanked, rsp_three_d, rsp_projector_id, rsp_frame_number,
                rsp_last_in_frame};
         words_seen <= words_seen + 1;
         if (expected_words.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %p", got);
         end else begin
            want = expected_words.pop_front();
            if (got !== want) begin
               mismatches++;
               if (mismatches <= 10) $display("mismatch\n exp %p\n got %p", want, got);
            end
         end
      end
   end

   task automatic push_byte(logic [7:0] d);
      file_byte_type fb;
      fb.data = d;
      fb.eof = 0;
      file_bytes.push_back(fb);
   endtask

   task automatic mark_last_eof();
      file_bytes[file_bytes.size() - 1].eof = 1;
   endtask

   task automatic add_header(logic [7:0] fmt, logic [15:0] cnt, logic [7:0] proj,
                             bit break_sig = 0);
      logic [7:0] d;
      int unsigned bad_at;
      bad_at = $urandom_range(0, 3);
      for (int p = 0; p < 32; p++) begin
         d = 8'($urandom);
         if (p < 4) d = (break_sig && p == bad_at) ? SIG_BYTES[p] ^ 8'($urandom_range(1, 255))
                                                  : SIG_BYTES[p];
         else if (p == 7) d = fmt;
         else if (p == 24) d = cnt[15:8];
         else if (p == 25) d = cnt[7:0];
         else if (p == 30) d = proj;
         push_byte(d);
      end
   endtask

   task automatic add_palette(logic [7:0] proj, int unsigned cnt);
      add_header(FMT_PALETTE, 16'(cnt), proj);
      for (int i = 0; i < 3 * cnt; i++) push_byte(8'($urandom));
   endtask

   // picks: colour indexes for indexed formats; extreme: full-scale coordinates
   task automatic add_points(logic [7:0] fmt, int unsigned cnt, logic [7:0] proj,
                             bit extreme = 0, int unsigned picks[$] = {});
      int unsigned stride, st;
      logic [7:0] d;
      stride = (fmt == FMT_3D_IDX) ? 8 : (fmt == FMT_2D_IDX) ? 6 :
               (fmt == FMT_3D_TRUE) ? 10 : 8;
      st = (fmt == FMT_3D_IDX || fmt == FMT_3D_TRUE) ? 6 : 4;
      add_header(fmt, 16'(cnt), proj);
      for (int i = 0; i < cnt; i++)
         for (int p = 0; p < stride; p++) begin
            d = 8'($urandom);
            if (extreme && p < st) d = (i % 2) ? ((p % 2) ? 8'h00 : 8'h80)
                                                : ((p % 2) ? 8'hFF : 8'h7F);
            if (p == st + 1 && i < picks.size()) d = 8'(picks[i]);
            push_byte(d);
         end
   endtask

   task automatic wait_quiet();
      while (file_bytes.size() != 0 || req_valid || expected_words.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(logic idx, logic [23:0] val);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      if (idx == CSR_MAX_POINTS) lim_points = val;
      else lim_frames = val[15:0];
      csr_valid <= 0;
      @(posedge clock);
   endtask

   task automatic add_random_section(output int unsigned nbytes);
      int unsigned start_size, fsel;
      logic [7:0] fmts [4] = '{FMT_3D_IDX, FMT_2D_IDX, FMT_3D_TRUE, FMT_2D_TRUE};
      start_size = file_bytes.size();
      if ($urandom_range(0, 4) == 0) add_palette(8'($urandom_range(0, PALETTE_SETS - 1)),
                                                 $urandom_range(2, 8));
      else begin
         fsel = $urandom_range(0, 3);
         add_points(fmts[fsel], $urandom_range(1, 10),
                    8'($urandom_range(0, PALETTE_SETS - 1)));
      end
      nbytes = file_bytes.size() - start_size;
   endtask

   initial begin
      int unsigned sent, n, ending, cut, stride;
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed: loaded, default and black colours, all point formats, extremes
      add_palette(0, 2);
      add_points(FMT_3D_IDX, 3, 0, 1, '{0, 1, 2});
      add_points(FMT_2D_IDX, 6, 1, 1, '{0, 16, 23, 40, 63, 255});
      add_points(FMT_3D_TRUE, 2, 2, 1);
      add_points(FMT_2D_TRUE, 1, 8'(PALETTE_SETS - 1));
      add_palette(8'(PALETTE_SETS - 1), 256);
      add_points(FMT_2D_IDX, 3, 8'(PALETTE_SETS - 1), 0, '{255, 0, 128});
      wait_quiet();

      // zero limits only gate point sections; a palette passes
      write_reg(CSR_MAX_POINTS, 24'h0);
      write_reg(CSR_MAX_FRAMES, 24'h0);
      add_palette(3, 4);
      wait_quiet();
      write_reg(CSR_MAX_POINTS, 24'hFFFFFF);
      write_reg(CSR_MAX_FRAMES, 24'hFFFF);

      sent = 0;
      for (int s = 1; sent < 1050; s++) begin
         add_random_section(n);
         sent += n;
         if (s % 5 == 0) begin
            wait_quiet();
            write_reg(CSR_MAX_POINTS, 24'($urandom_range(pts_total + 2000, 24'hFFFFFF)));
            write_reg(CSR_MAX_FRAMES, 24'($urandom_range(frm_total + 50, 16'hFFFF)));
         end
      end
      wait_quiet();

      // closing section picks how the file ends
      calm = 1;
      ending = $urandom_range(0, 7);
      case (ending)
         0: add_header(FMT_3D_TRUE, 0, 8'($urandom));
         1: add_header(FMT_2D_IDX, 4, 0, 1);
         2: add_header($urandom_range(0, 1) ? 8'd3 : 8'($urandom_range(6, 255)), 4, 0);
         3: add_header(FMT_PALETTE, 16'($urandom_range(0, 1) ? $urandom_range(0, 1)
                                                          : $urandom_range(257, 65535)), 0);
         4: begin
            add_points(FMT_3D_IDX, 3, 1);
            stride = 8;
            cut = $urandom_range(1, 3 * stride - 1);
            repeat (3 * stride - cut) void'(file_bytes.pop_back());
            mark_last_eof();
         end
         5: begin
            if ($urandom_range(0, 1)) write_reg(CSR_MAX_FRAMES, 24'(frm_total));
            else write_reg(CSR_MAX_POINTS, 24'(pts_total));
            add_points(FMT_2D_TRUE, 2, 0);
         end
         6: begin
            if ($urandom_range(0, 1)) begin
               add_header(FMT_3D_IDX, 2, 0);
               repeat ($urandom_range(1, 31)) void'(file_bytes.pop_back());
            end else add_points(FMT_2D_IDX, 2, 0);
            mark_last_eof();
         end
         default: add_header($urandom_range(0, 1) ? FMT_PALETTE : FMT_3D_IDX, 4,
                             8'($urandom_range(PALETTE_SETS, 255)));
      endcase
      // bytes after the status word are dropped
      if (ending != 4 && ending != 6) begin
         repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
         mark_last_eof();
      end
      wait_quiet();
      repeat (20) @(posedge clock);

      if (mismatches == 0 && expected_words.size() == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end

endmodule
`default_nettype wire
